/* sv/smwl_pkg.sv */
// Package with the command, result and state types of the stepper move controller.
`default_nettype none

package smwl_pkg;

  localparam int unsigned StepCountW = 16;
  localparam int unsigned EdgeW      = StepCountW + 1;
  localparam int unsigned PrescaleW  = 8;
  localparam int unsigned SpanW      = 16;
  localparam int unsigned ApbDataW   = 32;
  localparam int unsigned ApbAddrW   = 3;

  localparam logic [PrescaleW-1:0] HalfPeriodReset = 8'd77;
  localparam logic                 RegHalfPeriod   = 1'b0;

  typedef enum logic [1:0] {
    MODE_TICK  = 2'd0,
    MODE_MOVE  = 2'd1,
    MODE_ABORT = 2'd2,
    MODE_CALIB = 2'd3
  } smwl_mode_e;

  typedef enum logic [1:0] {
    PH_IDLE       = 2'd0,
    PH_SEEK_CCW   = 2'd1,
    PH_MEASURE_CW = 2'd2
  } smwl_phase_e;

  localparam logic DirCw  = 1'b0;
  localparam logic DirCcw = 1'b1;

  typedef struct packed {
    logic [1:0]            mode;
    logic [StepCountW-1:0] step_count;
    logic                  move_direction;
    logic                  ccw_limit;
    logic                  cw_limit;
  } smwl_cmd_t;

  typedef struct packed {
    logic             step_level;
    logic             direction_level;
    logic             drive_enabled;
    logic             busy_res;
    logic             status;
    logic             calibrating;
    logic [SpanW-1:0] span_steps;
    logic             span_valid;
  } smwl_res_t;

  typedef struct packed {
    logic [EdgeW-1:0]     edges_left;
    logic [PrescaleW-1:0] prescale_count;
    logic                 step_out;
    logic                 dir_out;
    logic                 moving;
    smwl_phase_e          calib_phase;
    logic [SpanW-1:0]     span_count;
  } smwl_state_t;

endpackage

`default_nettype wire

/* sv/smwl_stream_if.sv */
// Valid/ready stream interface that carries one payload per transaction.
`default_nettype none

interface smwl_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* sv/smwl_step_core.sv */
// Next-state and result logic for one command of the stepper move controller.
`default_nettype none

module smwl_step_core (
  input  smwl_pkg::smwl_state_t                   state_i,
  input  smwl_pkg::smwl_cmd_t                     cmd_i,
  input  logic [smwl_pkg::PrescaleW-1:0]          half_period_i,
  output smwl_pkg::smwl_state_t                   state_o,
  output smwl_pkg::smwl_res_t                     res_o
);
  import smwl_pkg::*;

  function automatic smwl_state_t begin_move(smwl_state_t s, logic [StepCountW-1:0] steps,
                                             logic dir);
    smwl_state_t r;
    r                = s;
    r.dir_out        = dir;
    r.edges_left     = {steps, 1'b0};
    r.prescale_count = '0;
    r.moving         = (steps != '0);
    return r;
  endfunction

  smwl_state_t      nxt;
  logic             busy;
  logic             status;
  logic             span_valid;
  logic             ended;
  logic             lim;
  logic [EdgeW-1:0] edges_dec;
  smwl_mode_e       mode;

  assign mode = smwl_mode_e'(cmd_i.mode);
  assign busy = state_i.moving || (state_i.calib_phase == PH_SEEK_CCW) ||
                (state_i.calib_phase == PH_MEASURE_CW);
  assign lim       = state_i.dir_out ? cmd_i.ccw_limit : cmd_i.cw_limit;
  assign edges_dec = state_i.edges_left - EdgeW'(1);

  always_comb begin
    nxt        = state_i;
    status     = 1'b0;
    span_valid = 1'b0;
    ended      = 1'b0;
    unique case (mode)
      MODE_MOVE: begin
        if (busy) begin
          status = 1'b1;
        end else begin
          nxt = begin_move(state_i, cmd_i.step_count, cmd_i.move_direction);
        end
      end
      MODE_CALIB: begin
        if (busy) begin
          status = 1'b1;
        end else begin
          nxt             = begin_move(state_i, StepCountW'(1), DirCcw);
          nxt.calib_phase = PH_SEEK_CCW;
          nxt.span_count  = '0;
        end
      end
      MODE_ABORT: begin
        nxt.edges_left  = '0;
        nxt.moving      = 1'b0;
        nxt.calib_phase = PH_IDLE;
      end
      MODE_TICK: begin
        if (state_i.moving) begin
          if (state_i.prescale_count == half_period_i) begin
            // Toggle the step pin; a move ends on the last edge or on a limit after a full step
            nxt.prescale_count = '0;
            nxt.step_out       = ~state_i.step_out;
            nxt.edges_left     = edges_dec;
            ended = (edges_dec == '0) || (state_i.step_out && lim);
          end else begin
            nxt.prescale_count = state_i.prescale_count + PrescaleW'(1);
          end
          if (ended) begin
            nxt.moving = 1'b0;
            unique case (state_i.calib_phase)
              PH_SEEK_CCW: begin
                if (cmd_i.ccw_limit) begin
                  nxt             = begin_move(nxt, StepCountW'(1), DirCw);
                  nxt.calib_phase = PH_MEASURE_CW;
                end else begin
                  nxt = begin_move(nxt, StepCountW'(1), DirCcw);
                end
              end
              PH_MEASURE_CW: begin
                nxt.span_count = state_i.span_count + SpanW'(1);
                if (cmd_i.cw_limit) begin
                  span_valid      = 1'b1;
                  nxt.calib_phase = PH_IDLE;
                end else begin
                  nxt = begin_move(nxt, StepCountW'(1), DirCw);
                end
              end
              default: ;
            endcase
          end
        end
      end
      default: ;
    endcase
  end

  assign state_o = nxt;

  always_comb begin
    res_o.step_level      = nxt.step_out;
    res_o.direction_level = nxt.dir_out;
    res_o.drive_enabled   = nxt.moving;
    res_o.busy_res        = nxt.moving;
    res_o.status          = status;
    res_o.calibrating     = (nxt.calib_phase == PH_SEEK_CCW) ||
                            (nxt.calib_phase == PH_MEASURE_CW);
    res_o.span_steps      = nxt.span_count;
    res_o.span_valid      = span_valid;
  end

endmodule

`default_nettype wire

/* sv/stepper_move_with_limit_calibration.sv */
// Top level of the stepper move controller with limit switches and span calibration.
// Path: an accepted command transaction gives its result through the input register, then
//   the state update that loads the result register.
// Throughput: one command per cycle unless res_o stalls; the state update is the only loop.
// Reset: rst_ni clears all motion state, the calibration phase and the span counter,
//   empties both pipeline registers and loads half_period with 77.
`default_nettype none

module stepper_move_with_limit_calibration (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  smwl_stream_if.sink                   cmd_i,
  smwl_stream_if.source                 res_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [smwl_pkg::ApbAddrW-1:0] paddr,
  input  logic [smwl_pkg::ApbDataW-1:0] pwdata,
  output logic [smwl_pkg::ApbDataW-1:0] prdata,
  output logic                          pready
);
  import smwl_pkg::*;

  // Configuration register: half_period sits at byte address 0.
  logic [PrescaleW-1:0] half_period_q;
  logic                 cfg_write;
  logic                 sel_half_period;

  assign pready          = 1'b1;
  assign sel_half_period = (paddr[ApbAddrW-1] == RegHalfPeriod);
  assign cfg_write       = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_period_q <= HalfPeriodReset;
    end else if (cfg_write && sel_half_period) begin
      half_period_q <= pwdata[PrescaleW-1:0];
    end
  end

  assign prdata = sel_half_period ? ApbDataW'(half_period_q) : '0;

  // Input register: take a new command whenever the slot is empty or drains this cycle.
  smwl_cmd_t cmd_q;
  logic      cmd_valid_q;
  logic      advance;
  logic      res_valid_q;

  assign advance     = cmd_valid_q && (!res_valid_q || res_o.ready);
  assign cmd_i.ready = !cmd_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_valid_q <= 1'b0;
    end else if (cmd_i.ready) begin
      cmd_valid_q <= cmd_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ready && cmd_i.valid) begin
      cmd_q <= cmd_i.data;
    end
  end

  // Motion state advances exactly once per command, as it moves into the result register.
  smwl_state_t state_q;
  smwl_state_t state_d;
  smwl_res_t   res_d;
  smwl_res_t   res_q;

  smwl_step_core u_core (
    .state_i       (state_q),
    .cmd_i         (cmd_q),
    .half_period_i (half_period_q),
    .state_o       (state_d),
    .res_o         (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{edges_left: '0, prescale_count: '0, step_out: 1'b0, dir_out: 1'b0,
                   moving: 1'b0, calib_phase: PH_IDLE, span_count: '0};
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // Result register: hold a finished result until the sink takes the transaction.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (advance) begin
      res_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid = res_valid_q;
  assign res_o.data  = res_q;

endmodule

`default_nettype wire

/* sv/smwl_checker.sv */
// Port-level checker for the stepper move controller, bound to the top level.
`default_nettype none

module smwl_checker (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     res_valid,
  input logic                     res_ready,
  input smwl_pkg::smwl_res_t      res_data
);
  import smwl_pkg::*;

  // Drive enable always mirrors the busy flag.
  a_drive_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> (res_data.drive_enabled == res_data.busy_res))
    else $error("drive_enabled differs from busy_res");

  // A completed calibration leaves the calibration phase.
  a_span_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && res_data.span_valid) |-> !res_data.calibrating)
    else $error("span_valid while still calibrating");

  // A rejected command leaves the block busy.
  a_reject_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && res_data.status) |-> (res_data.busy_res || res_data.calibrating))
    else $error("command rejected while idle");

  // A stalled result holds.
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && !res_ready) |=> (res_valid && $stable(res_data)))
    else $error("stalled result changed");

endmodule

bind stepper_move_with_limit_calibration smwl_checker u_smwl_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .res_valid (res_o.valid),
  .res_ready (res_o.ready),
  .res_data  (res_o.data)
);

`default_nettype wire
